### hdl/range_band_running_stats_assert.svh
// Assertion macros for the range band running statistics block.
// Included by the top level; no other dependencies.
`ifndef RANGE_BAND_RUNNING_STATS_ASSERT_SVH
`define RANGE_BAND_RUNNING_STATS_ASSERT_SVH

`ifndef SYNTHESIS
`define RBRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbrs: assertion failed");
`define RBRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbrs: assertion failed");
`else
`define RBRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RBRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/rbrs_pkg.sv
// Shared widths, reset values and codes for range_band_running_stats.
// No dependencies.
package rbrs_pkg;

    localparam int CNT_W  = 32;
    localparam int SMP_W  = 14;
    localparam int SUM_W  = 48;
    localparam int N_W    = CNT_W + 2;
    localparam int STEP_W = $clog2(SMP_W);
    localparam int CIDX_W = 2;

    localparam logic [SMP_W-1:0] LOW_RST  = SMP_W'(1120);
    localparam logic [SMP_W-1:0] HIGH_RST = SMP_W'(2880);

    localparam logic [CIDX_W-1:0] REG_LOW  = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_HIGH = CIDX_W'(1);

    typedef enum logic [1:0] {
        BAND_BELOW = 2'd0,
        BAND_IN    = 2'd1,
        BAND_ABOVE = 2'd2
    } t_band;

endpackage

### hdl/range_band_running_stats.sv
// Range band running statistics: band counters, running mean, sum of squared deviations.
// Depends on rbrs_pkg and range_band_running_stats_assert.svh.
//
//  channel  direction  handshake          payload
//  sample   in         i_valid / o_stall  i_sample
//  result   out        o_valid / i_stall  o_band, o_*_count, o_mean_value, o_sq_dev_sum
//  config   in         i_cfg_we           i_cfg_idx, i_cfg_wdata
//
// From accept to result an item goes through the sum of n, a bit-serial restoring
// divide of |x - mean| by n, the mean update and a bit-serial shift-add square.
// A new item is taken once the previous one has moved into the result register,
// so a new sample is not accepted while the previous one is still being worked on.
// A stalled result holds; the final commit waits until the result register is free.
// Synchronous reset clears counters, mean, sum and restores the thresholds.
`include "range_band_running_stats_assert.svh"

module range_band_running_stats (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [rbrs_pkg::SMP_W-1:0]       i_sample,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_band,
    output logic [rbrs_pkg::CNT_W-1:0]       o_below_count,
    output logic [rbrs_pkg::CNT_W-1:0]       o_inrange_count,
    output logic [rbrs_pkg::CNT_W-1:0]       o_above_count,
    output logic [rbrs_pkg::SMP_W-1:0]       o_mean_value,
    output logic [rbrs_pkg::SUM_W-1:0]       o_sq_dev_sum,
    input  logic                             i_cfg_we,
    input  logic [rbrs_pkg::CIDX_W-1:0]      i_cfg_idx,
    input  logic [rbrs_pkg::SMP_W-1:0]       i_cfg_wdata
);
    import rbrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_NSUM, S_NADD, S_DIV, S_MEAN, S_DEVS, S_MUL, S_DONE
    } t_state;

    t_state              r_state;
    logic                r_valid;
    t_band               r_band;
    logic [CNT_W-1:0]    r_below;
    logic [CNT_W-1:0]    r_inrange;
    logic [CNT_W-1:0]    r_above;
    logic [SMP_W-1:0]    r_mean;
    logic [SUM_W-1:0]    r_dev_sum;
    logic [SMP_W-1:0]    r_low;
    logic [SMP_W-1:0]    r_high;
    logic [STEP_W-1:0]   r_step;

    // working registers of the current item
    t_band               r_wband;
    logic [SMP_W-1:0]    r_x;
    logic [N_W-1:0]      r_n;
    logic                r_ge;
    logic [SMP_W-1:0]    r_dvd;
    logic [SMP_W-1:0]    r_rem;
    logic [SMP_W-1:0]    r_mnew;
    logic [SMP_W-1:0]    r_dev;
    logic [SMP_W-1:0]    r_mhi;
    logic [SMP_W-1:0]    r_mlo;

    t_band               n_band;
    logic                n_sel_sat;
    logic [SMP_W:0]      n_trial;
    logic                n_fit;
    logic [SMP_W:0]      n_diff;
    logic [SMP_W:0]      n_madd;
    logic [SMP_W:0]      n_mmean;
    logic [SMP_W-1:0]    n_absd;
    logic [SMP_W-1:0]    n_absdev;
    logic [SUM_W:0]      n_acc;
    logic                n_last;
    logic                n_commit;

    always_comb begin
        priority if (i_sample < r_low) begin
            n_band = BAND_BELOW;
        end else if (i_sample > r_high) begin
            n_band = BAND_ABOVE;
        end else begin
            n_band = BAND_IN;
        end
    end

    always_comb begin
        unique case (r_wband)
            BAND_BELOW: n_sel_sat = &r_below;
            BAND_ABOVE: n_sel_sat = &r_above;
            default:    n_sel_sat = &r_inrange;
        endcase
    end

    // restoring divide step: bring down the next dividend bit, subtract n if it fits
    assign n_trial = {r_rem, r_dvd[SMP_W-1]};
    assign n_fit   = {{(N_W-SMP_W-1){1'b0}}, n_trial} >= r_n;
    assign n_diff  = n_trial - r_n[SMP_W:0];

    // r_dvd holds the quotient after the divide; the new mean is rounded down
    assign n_madd  = {1'b0, r_mean} + {1'b0, r_dvd};
    assign n_mmean = {1'b0, r_mean} - {1'b0, r_dvd} - {{SMP_W{1'b0}}, (r_rem != '0)};

    assign n_absd   = (i_sample >= r_mean) ? (i_sample - r_mean) : (r_mean - i_sample);
    assign n_absdev = (r_x >= r_mnew) ? (r_x - r_mnew) : (r_mnew - r_x);

    assign n_acc    = {1'b0, r_dev_sum} + (SUM_W+1)'({r_mhi, r_mlo});
    assign n_last   = (r_step == STEP_W'(SMP_W - 1));
    assign n_commit = (r_state == S_DONE) && (!r_valid || !i_stall);

    // control, committed state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_band    <= BAND_BELOW;
            r_below   <= '0;
            r_inrange <= '0;
            r_above   <= '0;
            r_mean    <= '0;
            r_dev_sum <= '0;
            r_low     <= LOW_RST;
            r_high    <= HIGH_RST;
            r_step    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_LOW) begin
                    r_low <= i_cfg_wdata;
                end else if (i_cfg_idx == REG_HIGH) begin
                    r_high <= i_cfg_wdata;
                end
            end
            if (r_valid && !i_stall && !n_commit) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_NSUM;
                    end
                end
                S_NSUM: r_state <= S_NADD;
                S_NADD: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (n_last) begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: r_state <= S_DEVS;
                S_DEVS: begin
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (n_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_commit) begin
                        r_valid <= 1'b1;
                        r_band  <= r_wband;
                        r_mean  <= r_mnew;
                        r_dev_sum <= n_acc[SUM_W] ? {SUM_W{1'b1}} : n_acc[SUM_W-1:0];
                        unique case (r_wband)
                            BAND_BELOW: if (!n_sel_sat) r_below <= r_below + 1'b1;
                            BAND_ABOVE: if (!n_sel_sat) r_above <= r_above + 1'b1;
                            default:    if (!n_sel_sat) r_inrange <= r_inrange + 1'b1;
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath: shift registers of the divider and multiplier
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_x     <= i_sample;
                    r_wband <= n_band;
                    r_ge    <= (i_sample >= r_mean);
                    r_dvd   <= n_absd;
                end
            end
            S_NSUM: begin
                r_n   <= {2'b00, r_below} + {2'b00, r_inrange};
                r_rem <= '0;
            end
            S_NADD: begin
                r_n <= r_n + {2'b00, r_above} + {{(N_W-1){1'b0}}, !n_sel_sat};
            end
            S_DIV: begin
                r_rem <= n_fit ? n_diff[SMP_W-1:0] : n_trial[SMP_W-1:0];
                r_dvd <= {r_dvd[SMP_W-2:0], n_fit};
            end
            S_MEAN: begin
                r_mnew <= r_ge ? n_madd[SMP_W-1:0] : n_mmean[SMP_W-1:0];
            end
            S_DEVS: begin
                r_dev <= n_absdev;
                r_mhi <= '0;
                r_mlo <= n_absdev;
            end
            S_MUL: begin
                {r_mhi, r_mlo} <= {({1'b0, r_mhi} + (r_mlo[0] ? {1'b0, r_dev} : '0)),
                                   r_mlo[SMP_W-1:1]};
            end
            default: begin
            end
        endcase
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_band          = r_band;
    assign o_below_count   = r_below;
    assign o_inrange_count = r_inrange;
    assign o_above_count   = r_above;
    assign o_mean_value    = r_mean;
    assign o_sq_dev_sum    = r_dev_sum;

    `RBRS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `RBRS_ASSERT_NEXT(a_commit_sets_valid, i_clk, i_rst_n, n_commit, r_valid)
    `RBRS_ASSERT_IMPLY(a_divisor_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_n != '0)
    `RBRS_ASSERT_IMPLY(a_mean_between, i_clk, i_rst_n, r_state == S_DEVS, (r_ge && r_mnew >= r_mean && r_mnew <= r_x) || (!r_ge && r_mnew <= r_mean && r_mnew >= r_x))

endmodule
